@@ rtl/core/igrd_pkg.sv @@
// ----------------------------------------------------------------------------
// igrd_pkg
// Shared types and constants for the int8 GEMM row dot-product block.
// ----------------------------------------------------------------------------
package igrd_pkg;

  // Configuration register indexes
  localparam logic CFG_A_ROWS     = 1'b0;
  localparam logic CFG_ROW_LENGTH = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int A_ROWS_W   = 5;
  localparam int ROW_LEN_W  = 13;

  // Field widths of the input and result words
  localparam int ROW_W   = 16;
  localparam int POS_W   = 12;
  localparam int VAL_W   = 8;
  localparam int DOT_W   = 32;
  localparam int OROW_W  = 4;

  localparam logic KIND_A_WRITE = 1'b0;
  localparam logic KIND_B_ELEM  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr;     // store the A element of the current word
    logic rd;     // read all lanes at the current position, latch the B word
    logic mac;    // accumulate the products read last cycle
    logic clear;  // restart the accumulators with this product
    logic emit;   // present one accumulator on the result port
    logic last;   // the emitted result is the final active row
  } cmd_t;

endpackage

@@ rtl/core/igrd_lane.sv @@
// ----------------------------------------------------------------------------
// igrd_lane
// One resident A row: element memory, 8x8 signed multiplier and int32
// accumulator.
// ----------------------------------------------------------------------------
module igrd_lane #(
  parameter int MAX_DEPTH = 4096,
  parameter int ADDR_W    = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [igrd_pkg::VAL_W-1:0]     wr_data,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  input  logic                           mac,
  input  logic                           clear,
  input  logic signed [igrd_pkg::VAL_W-1:0] b_val,
  output logic [igrd_pkg::DOT_W-1:0]     acc
);

  logic [igrd_pkg::VAL_W-1:0] mem [MAX_DEPTH];
  logic [igrd_pkg::VAL_W-1:0] rd_data_r;
  logic [igrd_pkg::DOT_W-1:0] acc_r;
  logic [igrd_pkg::DOT_W-1:0] acc_nxt;
  logic signed [2*igrd_pkg::VAL_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign prod = $signed(rd_data_r) * b_val;

  always_comb begin
    acc_nxt = (clear ? '0 : acc_r) +
              {{(igrd_pkg::DOT_W-2*igrd_pkg::VAL_W){prod[2*igrd_pkg::VAL_W-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (mac) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/core/igrd_datapath.sv @@
// ----------------------------------------------------------------------------
// igrd_datapath
// Lanes for all resident A rows, B word latch and result register.
// ----------------------------------------------------------------------------
module igrd_datapath #(
  parameter int MAX_ROWS_A = 16,
  parameter int MAX_DEPTH  = 4096,
  parameter int IDX_W      = 4,
  parameter int ADDR_W     = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  igrd_pkg::cmd_t                    cmd,
  input  logic [IDX_W-1:0]                  emit_idx,
  input  logic [igrd_pkg::ROW_W-1:0]        in_row,
  input  logic [igrd_pkg::POS_W-1:0]        in_pos,
  input  logic signed [igrd_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [igrd_pkg::DOT_W-1:0] out_dot,
  output logic [igrd_pkg::OROW_W-1:0]       out_row,
  output logic [igrd_pkg::ROW_W-1:0]        out_col,
  output logic                              out_last
);

  logic [ADDR_W-1:0]                  addr;
  logic signed [igrd_pkg::VAL_W-1:0]  b_val_r;
  logic [igrd_pkg::ROW_W-1:0]         col_r;
  logic [igrd_pkg::DOT_W-1:0]         acc [MAX_ROWS_A];

  logic                               out_valid_r;
  logic [igrd_pkg::DOT_W-1:0]         out_dot_r;
  logic [igrd_pkg::OROW_W-1:0]        out_row_r;
  logic [igrd_pkg::ROW_W-1:0]         out_col_r;
  logic                               out_last_r;

  assign addr = ADDR_W'(in_pos);

  // Hold the B word for the accumulate cycle
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      b_val_r <= in_value;
      col_r   <= in_row;
    end
  end

  for (genvar i = 0; i < MAX_ROWS_A; i++) begin : g_lane
    igrd_lane #(
      .MAX_DEPTH (MAX_DEPTH),
      .ADDR_W    (ADDR_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (cmd.wr && (in_row == igrd_pkg::ROW_W'(i))),
      .wr_addr (addr),
      .wr_data (in_value),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .mac     (cmd.mac),
      .clear   (cmd.clear),
      .b_val   (b_val_r),
      .acc     (acc[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dot_r  <= acc[emit_idx];
      out_row_r  <= igrd_pkg::OROW_W'(emit_idx);
      out_col_r  <= col_r;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dot   = out_dot_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/core/igrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// igrd_ctrl
// Configuration registers and sequencer: accept, accumulate, emit results.
// ----------------------------------------------------------------------------
module igrd_ctrl #(
  parameter int MAX_ROWS_A = 16,
  parameter int MAX_DEPTH  = 4096,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5,
  parameter int KLEN_W     = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [igrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [igrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                start,
  input  logic                                in_kind,
  input  logic [igrd_pkg::ROW_W-1:0]          in_row,
  input  logic [igrd_pkg::POS_W-1:0]          in_pos,
  output logic                                busy,
  output igrd_pkg::cmd_t                      cmd,
  output logic [IDX_W-1:0]                    emit_idx
);

  logic [igrd_pkg::A_ROWS_W-1:0]  a_rows_r;
  logic [igrd_pkg::ROW_LEN_W-1:0] row_length_r;

  igrd_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             clear_r, clear_nxt;
  logic             last_pos_r, last_pos_nxt;

  logic [CNT_W-1:0]  m_eff;
  logic [KLEN_W-1:0] k_eff;
  logic [IDX_W-1:0]  idx_top;
  logic              accept;
  logic              a_ok;
  logic              b_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r     <= igrd_pkg::A_ROWS_W'(1);
      row_length_r <= igrd_pkg::ROW_LEN_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        igrd_pkg::CFG_A_ROWS:     a_rows_r     <= cfg_wdata[igrd_pkg::A_ROWS_W-1:0];
        igrd_pkg::CFG_ROW_LENGTH: row_length_r <= cfg_wdata[igrd_pkg::ROW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configured sizes into the supported range
  always_comb begin
    if (a_rows_r == '0) begin
      m_eff = CNT_W'(1);
    end else if (32'(a_rows_r) > 32'(MAX_ROWS_A)) begin
      m_eff = CNT_W'(MAX_ROWS_A);
    end else begin
      m_eff = CNT_W'(a_rows_r);
    end
    if (row_length_r == '0) begin
      k_eff = KLEN_W'(1);
    end else if (32'(row_length_r) > 32'(MAX_DEPTH)) begin
      k_eff = KLEN_W'(MAX_DEPTH);
    end else begin
      k_eff = KLEN_W'(row_length_r);
    end
  end

  assign idx_top = IDX_W'(m_eff - CNT_W'(1));
  assign accept  = start && !busy;
  assign a_ok    = (32'(in_row) < 32'(m_eff)) && (32'(in_pos) < 32'(MAX_DEPTH));
  assign b_ok    = 32'(in_pos) < 32'(k_eff);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    clear_nxt    = clear_r;
    last_pos_nxt = last_pos_r;
    cmd          = '0;
    case (state_r)
      igrd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == igrd_pkg::KIND_A_WRITE) begin
            cmd.wr = a_ok;
          end else if (b_ok) begin
            cmd.rd       = 1'b1;
            clear_nxt    = (in_pos == '0);
            last_pos_nxt = (32'(in_pos) == 32'(k_eff) - 32'd1);
            state_nxt    = igrd_pkg::ST_MAC;
          end
        end
      end
      igrd_pkg::ST_MAC: begin
        cmd.mac   = 1'b1;
        cmd.clear = clear_r;
        idx_nxt   = '0;
        state_nxt = last_pos_r ? igrd_pkg::ST_EMIT : igrd_pkg::ST_IDLE;
      end
      igrd_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = (idx_r == idx_top);
        if (idx_r == idx_top) begin
          state_nxt = igrd_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = igrd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= igrd_pkg::ST_IDLE;
      idx_r      <= '0;
      clear_r    <= 1'b0;
      last_pos_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      clear_r    <= clear_nxt;
      last_pos_r <= last_pos_nxt;
    end
  end

  assign busy     = (state_r != igrd_pkg::ST_IDLE);
  assign emit_idx = idx_r;

endmodule

@@ rtl/core/int8_gemm_row_dot_top.sv @@
// ----------------------------------------------------------------------------
// int8_gemm_row_dot_top
// Signed int8 matrix product with exact int32 accumulation, one B row
// streamed against up to MAX_ROWS_A resident A rows.
//
// Usage: set a_rows (index 0) and row_length (index 1) through the cfg_
// write port while the block is idle. Load A with words of kind 0 (row,
// pos, value); then stream each B row with words of kind 1 in position
// order. A word is taken when start is high and busy is low.
// An A write or an out-of-range B element leaves busy low. A B element
// reads every lane memory, then does one multiply-accumulate per lane in
// parallel. On the final position the block then emits one result per
// active A row, one per cycle. out_valid marks each result for one
// cycle, one register after the accumulators; out_last flags the final row.
// The receiver cannot stall, so results leave at that fixed rate.
// Reset clears the accumulators, the sequencer and the configuration
// (a_rows 1, row_length 64); A memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module int8_gemm_row_dot_top #(
  parameter int MAX_ROWS_A = 16,
  parameter int MAX_DEPTH  = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [igrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [igrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_kind,
  input  logic [igrd_pkg::ROW_W-1:0]          in_row,
  input  logic [igrd_pkg::POS_W-1:0]          in_pos,
  input  logic signed [igrd_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  output logic signed [igrd_pkg::DOT_W-1:0]   out_dot,
  output logic [igrd_pkg::OROW_W-1:0]         out_row,
  output logic [igrd_pkg::ROW_W-1:0]          out_col,
  output logic                                out_last
);

  localparam int IDX_W  = (MAX_ROWS_A > 1) ? $clog2(MAX_ROWS_A) : 1;
  localparam int CNT_W  = $clog2(MAX_ROWS_A + 1);
  localparam int ADDR_W = $clog2(MAX_DEPTH);
  localparam int KLEN_W = $clog2(MAX_DEPTH + 1);

  igrd_pkg::cmd_t   cmd;
  logic [IDX_W-1:0] emit_idx;

  igrd_ctrl #(
    .MAX_ROWS_A (MAX_ROWS_A),
    .MAX_DEPTH  (MAX_DEPTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .KLEN_W     (KLEN_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_kind   (in_kind),
    .in_row    (in_row),
    .in_pos    (in_pos),
    .busy      (busy),
    .cmd       (cmd),
    .emit_idx  (emit_idx)
  );

  igrd_datapath #(
    .MAX_ROWS_A (MAX_ROWS_A),
    .MAX_DEPTH  (MAX_DEPTH),
    .IDX_W      (IDX_W),
    .ADDR_W     (ADDR_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .emit_idx  (emit_idx),
    .in_row    (in_row),
    .in_pos    (in_pos),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_dot   (out_dot),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last)
  );

endmodule

@@ sim/igrd_dot_tracker_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// igrd_dot_tracker_pkg
// Tracks the resident A rows, the row accumulators and the two config
// registers of the int8 GEMM row block. Works out the dot products that
// every accepted word should produce and checks them in order.
// ----------------------------------------------------------------------------
package igrd_dot_tracker_pkg;
  import igrd_pkg::*;

  localparam int TRK_ROWS  = 16;
  localparam int TRK_DEPTH = 4096;

  typedef struct {
    int                dot;
    bit [OROW_W-1:0]   arow;
    bit [ROW_W-1:0]    col;
    bit                last;
  } dot_due_t;

  class row_dot_tracker;
    bit signed [VAL_W-1:0] a_mem [TRK_ROWS][TRK_DEPTH];
    bit                    loaded [TRK_ROWS][TRK_DEPTH];
    int                    sums [TRK_ROWS];
    bit [A_ROWS_W-1:0]     a_rows_reg;
    bit [ROW_LEN_W-1:0]    len_reg;
    dot_due_t              dots_due [$];
    int                    errors;
    int                    dots_checked;

    function new();
      a_rows_reg = 5'd1;
      len_reg    = 13'd64;
      foreach (sums[i]) sums[i] = 0;
      errors       = 0;
      dots_checked = 0;
    endfunction

    function int rows_in_use();
      if (a_rows_reg == 0) return 1;
      if (a_rows_reg > TRK_ROWS) return TRK_ROWS;
      return a_rows_reg;
    endfunction

    function int length_in_use();
      if (len_reg == 0) return 1;
      if (len_reg > TRK_DEPTH) return TRK_DEPTH;
      return len_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_A_ROWS) begin
        a_rows_reg = data[A_ROWS_W-1:0];
      end else begin
        len_reg = data[ROW_LEN_W-1:0];
      end
    endfunction

    function int pending();
      return dots_due.size();
    endfunction

    // Returns 1 when the word changes state, 0 when the block drops it.
    function bit take_word(logic kind, logic [ROW_W-1:0] row, logic [POS_W-1:0] pos,
                           logic signed [VAL_W-1:0] value);
      int       m;
      int       k;
      int       a;
      int       b;
      dot_due_t due;
      m = rows_in_use();
      k = length_in_use();
      b = value;
      if (kind == KIND_A_WRITE) begin
        if (row >= m) return 1'b0;
        a_mem[row][pos]  = value;
        loaded[row][pos] = 1'b1;
        return 1'b1;
      end
      if (pos >= k) return 1'b0;
      if (pos == 0) foreach (sums[i]) sums[i] = 0;
      for (int i = 0; i < m; i++) begin
        a = a_mem[i][pos];
        sums[i] += a * b;
      end
      if (pos == k - 1) begin
        for (int i = 0; i < m; i++) begin
          due.dot  = sums[i];
          due.arow = OROW_W'(i);
          due.col  = row;
          due.last = (i == m - 1);
          dots_due.push_back(due);
        end
      end
      return 1'b1;
    endfunction

    function void check_dot(logic signed [DOT_W-1:0] dot, logic [OROW_W-1:0] arow,
                            logic [ROW_W-1:0] col, logic last);
      dot_due_t due;
      dots_checked++;
      if (dots_due.size() == 0) begin
        $error("unexpected dot product %0d (row %0d, col %0d)", dot, arow, col);
        errors++;
        return;
      end
      due = dots_due.pop_front();
      if (dot !== due.dot) begin
        $error("out_dot: expected %0d, got %0d", due.dot, dot);
        errors++;
      end
      if (arow !== due.arow) begin
        $error("out_row: expected %0d, got %0d", due.arow, arow);
        errors++;
      end
      if (col !== due.col) begin
        $error("out_col: expected %0d, got %0d", due.col, col);
        errors++;
      end
      if (last !== due.last) begin
        $error("out_last: expected %0d, got %0d", due.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for int8_gemm_row_dot_top. Loads A rows, streams B rows in
// order (sparse for long rows), mixes in dropped and out-of-order words,
// and sweeps row count and row length including out-of-range settings.
// Every dot product is checked against a tracker of the block's state.
// ----------------------------------------------------------------------------
module tb;
  import igrd_pkg::*;
  import igrd_dot_tracker_pkg::*;

  localparam int DENSE_MAX   = 24;    // rows up to this length are streamed whole
  localparam int DRAIN       = 22;    // covers the read, accumulate and emit states of a final element
  localparam int STALL_LIMIT = 2000;
  localparam int LIVE_TARGET = 380;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 8'sh80;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 8'sh7F;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     start     = 1'b0;
  logic                     busy;
  logic                     in_kind   = 1'b0;
  logic [ROW_W-1:0]         in_row    = '0;
  logic [POS_W-1:0]         in_pos    = '0;
  logic signed [VAL_W-1:0]  in_value  = '0;
  logic                     out_valid;
  logic signed [DOT_W-1:0]  out_dot;
  logic [OROW_W-1:0]        out_row;
  logic [ROW_W-1:0]         out_col;
  logic                     out_last;

  row_dot_tracker sb;
  bit             no_gaps     = 1'b0;
  int             live_words  = 0;
  int             all_words   = 0;
  int             settings    = 0;
  int             idle_cycles = 0;

  int8_gemm_row_dot_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_kind   (in_kind),
    .in_row    (in_row),
    .in_pos    (in_pos),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_dot   (out_dot),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_dot(out_dot, out_row, out_col, out_last);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word or result moved for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic idle_in();
    start <= 1'b0;
  endtask

  // Hold start until the word is taken; keep it high for a back-to-back word.
  task automatic put_word(input logic kind, input logic [ROW_W-1:0] row,
                          input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= kind;
    in_row   <= row;
    in_pos   <= pos;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    all_words++;
    if (sb.take_word(kind, row, pos, value)) live_words++;
  endtask

  // A B element; first fill any A entry it would read that was never written.
  task automatic put_b(input logic [ROW_W-1:0] col, input logic [POS_W-1:0] pos,
                       input logic signed [VAL_W-1:0] value);
    int m;
    m = sb.rows_in_use();
    if (pos < sb.length_in_use()) begin
      for (int i = 0; i < m; i++) begin
        if (!sb.loaded[i][pos]) put_word(KIND_A_WRITE, ROW_W'(i), pos, pick_value());
      end
    end
    put_word(KIND_B_ELEM, col, pos, value);
  endtask

  task automatic stream_b_row(input logic [ROW_W-1:0] col);
    int k;
    k = sb.length_in_use();
    if (k <= DENSE_MAX) begin
      for (int p = 0; p < k; p++) put_b(col, POS_W'(p), pick_value());
    end else begin
      // long row: start, a few inner positions out of order, then the end
      put_b(col, '0, pick_value());
      repeat ($urandom_range(1, 3)) put_b(col, POS_W'($urandom_range(1, k - 2)), pick_value());
      put_b(col, POS_W'(k - 1), pick_value());
    end
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows_data,
                           input logic [CFG_DATA_W-1:0] len_data);
    idle_in();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_A_ROWS;
    cfg_wdata <= rows_data;
    @(posedge clk);
    sb.write_reg(CFG_A_ROWS, rows_data);
    cfg_index <= CFG_ROW_LENGTH;
    cfg_wdata <= len_data;
    @(posedge clk);
    sb.write_reg(CFG_ROW_LENGTH, len_data);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin : main
    int                m_val;
    int                k_val;
    int                m;
    int                k;
    logic [ROW_W-1:0]  col;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one row, length 64; two positions carry the product.
    put_word(KIND_A_WRITE, 16'd0, 12'd0, VAL_MIN);
    put_word(KIND_A_WRITE, 16'd0, 12'd63, VAL_MAX);
    put_word(KIND_A_WRITE, 16'd1, 12'd0, 8'sd55);          // inactive row, dropped
    put_word(KIND_A_WRITE, 16'hFFFF, 12'hFFF, '1);         // inactive row, dropped
    put_word(KIND_A_WRITE, 16'd0, 12'hFFF, VAL_MIN);       // past the length, stored
    put_b(16'd0, 12'd0, VAL_MIN);
    put_b(16'd0, 12'd64, VAL_MAX);                          // past the length, dropped
    put_b(16'd0, 12'hFFF, VAL_MAX);                         // dropped
    put_b(16'hFFFF, 12'd63, VAL_MAX);

    // Zero row count and zero length both act as one: single-element rows.
    configure('0, '0);
    put_b(16'h00FF, 12'd0, VAL_MAX);
    put_b(16'h0001, 12'd1, VAL_MIN);

    // Both registers above range; repeat the last position without a restart.
    configure(13'h1FFF, 13'h1FFF);
    put_b(16'hAAAA, 12'd0, VAL_MIN);
    put_b(16'h5555, 12'hFFF, VAL_MIN);
    put_b(16'h5555, 12'hFFF, VAL_MAX);

    configure(13'd16, 13'd4096);
    stream_b_row(ROW_W'($urandom));

    while (live_words < LIVE_TARGET) begin
      case ($urandom_range(0, 9))
        0: m_val = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        1: m_val = 16;
        default: m_val = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0: k_val = 0;
        1: k_val = $urandom_range(0, 1) ? 4096 : $urandom_range(4097, 8191);
        2: k_val = $urandom_range(DENSE_MAX + 1, 4095);
        default: k_val = $urandom_range(1, 12);
      endcase
      configure({8'($urandom), 5'(m_val)}, 13'(k_val));
      m = sb.rows_in_use();
      k = sb.length_in_use();
      no_gaps = ($urandom_range(0, 3) == 0);

      if (k <= DENSE_MAX) begin
        for (int i = 0; i < m; i++) begin
          for (int p = 0; p < k; p++) put_word(KIND_A_WRITE, ROW_W'(i), POS_W'(p), pick_value());
        end
      end

      repeat ($urandom_range(2, 6)) begin
        col = ROW_W'($urandom);
        case ($urandom_range(0, 9))
          0: begin
            // drop: inactive row, or B element past the length
            put_word(KIND_A_WRITE, ROW_W'($urandom_range(m, 65535)), POS_W'($urandom),
                     pick_value());
            if (k < TRK_DEPTH) put_b(col, POS_W'($urandom_range(k, TRK_DEPTH - 1)), pick_value());
          end
          1: begin
            // broken row: restart and a stray middle position, no end
            put_b(col, '0, pick_value());
            if (k > 2) put_b(col, POS_W'($urandom_range(1, k - 2)), pick_value());
          end
          2: begin
            if ($urandom_range(0, 1)) begin
              put_b(col, POS_W'($urandom), VAL_W'($urandom));
            end else begin
              put_word(KIND_A_WRITE, ROW_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
            end
          end
          default: stream_b_row(col);
        endcase
      end
    end

    no_gaps = 1'b0;
    idle_in();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d words (%0d not dropped), %0d dot products, %0d register settings",
             all_words, live_words, sb.dots_checked, settings);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
